FILE: rtl/kbt_pkg.sv
package kbt_pkg;

	typedef enum logic [1:0] {
		MODE_JOIN    = 2'd0,
		MODE_WAIT    = 2'd1,
		MODE_DESTROY = 2'd2,
		MODE_CLEANUP = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_RANGE    = 3'd1,
		ST_NOT_LIVE = 3'd2,
		ST_FULL     = 3'd3,
		ST_BROKEN   = 3'd4,
		ST_MISMATCH = 3'd5
	} status_t;

	localparam int unsigned KeyWidth   = 32;
	localparam int unsigned GoalWidth  = 7;
	localparam int unsigned IndexWidth = 8;
	localparam int unsigned SlotWidth  = 6;
	localparam int unsigned IdWidth    = 4;
	localparam int unsigned FreedWidth = 16;

	// Write strobes from the sequencer into the entry storage.
	typedef struct packed {
		logic mask_we;
		logic meta_we;
		logic count_we;
	} store_wr_t;

	// Flags produced by the shared compare unit for the entry under access.
	typedef struct packed {
		logic live;
		logic key_hit;
		logic goal_hit;
		logic bit_set;
		logic left_empty;
		logic broken;
		logic reached;
	} unit_res_t;

	typedef struct packed {
		logic [FreedWidth-1:0] released_mask;
		logic                  release_waiters;
		logic                  caller_blocks;
		logic [IdWidth-1:0]    barrier_id;
		status_t               status;
	} result_t;

endpackage

FILE: rtl/kbt_store.sv
module kbt_store #(
	parameter int unsigned NUM_BARRIERS = 16,
	parameter int unsigned NUM_PROCS    = 64,
	localparam int unsigned IW = (NUM_BARRIERS > 1) ? $clog2(NUM_BARRIERS) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [IW-1:0]                   rd_idx,
	input  kbt_pkg::store_wr_t              wr,
	input  logic [kbt_pkg::KeyWidth-1:0]    wr_key,
	input  logic [kbt_pkg::GoalWidth-1:0]   wr_goal,
	input  logic [kbt_pkg::GoalWidth-1:0]   wr_count,
	input  logic [NUM_PROCS-1:0]            wr_mask,
	output logic [kbt_pkg::KeyWidth-1:0]    ent_key,
	output logic [kbt_pkg::GoalWidth-1:0]   ent_goal,
	output logic [kbt_pkg::GoalWidth-1:0]   ent_count,
	output logic [NUM_PROCS-1:0]            ent_mask
);

	logic [kbt_pkg::KeyWidth-1:0]  key_q   [NUM_BARRIERS];
	logic [kbt_pkg::GoalWidth-1:0] goal_q  [NUM_BARRIERS];
	logic [kbt_pkg::GoalWidth-1:0] count_q [NUM_BARRIERS];
	logic [NUM_PROCS-1:0]          mask_q  [NUM_BARRIERS];

	// A nonzero user mask marks a live entry, so only the masks are cleared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(NUM_BARRIERS); i++) begin
				mask_q[i] <= '0;
			end
		end else if (wr.mask_we) begin
			mask_q[rd_idx] <= wr_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.meta_we) begin
			key_q[rd_idx]  <= wr_key;
			goal_q[rd_idx] <= wr_goal;
		end
		if (wr.meta_we || wr.count_we) begin
			count_q[rd_idx] <= wr_count;
		end
	end

	assign ent_key   = key_q[rd_idx];
	assign ent_goal  = goal_q[rd_idx];
	assign ent_count = count_q[rd_idx];
	assign ent_mask  = mask_q[rd_idx];

endmodule

FILE: rtl/kbt_unit.sv
module kbt_unit #(
	parameter int unsigned NUM_PROCS = 64
) (
	input  logic [kbt_pkg::KeyWidth-1:0]  req_key,
	input  logic [kbt_pkg::GoalWidth-1:0] req_goal,
	input  logic [kbt_pkg::SlotWidth-1:0] req_slot,
	input  logic [kbt_pkg::KeyWidth-1:0]  ent_key,
	input  logic [kbt_pkg::GoalWidth-1:0] ent_goal,
	input  logic [kbt_pkg::GoalWidth-1:0] ent_count,
	input  logic [NUM_PROCS-1:0]          ent_mask,
	output kbt_pkg::unit_res_t            res,
	output logic [NUM_PROCS-1:0]          mask_set,
	output logic [NUM_PROCS-1:0]          mask_clr,
	output logic [kbt_pkg::GoalWidth-1:0] count_next
);

	localparam logic [NUM_PROCS-1:0] SlotOne = NUM_PROCS'(1);

	logic [NUM_PROCS-1:0] slot_bit;

	assign slot_bit   = SlotOne << req_slot;
	assign mask_set   = ent_mask | slot_bit;
	assign mask_clr   = ent_mask & ~slot_bit;
	assign count_next = ent_count + kbt_pkg::GoalWidth'(1);

	always_comb begin
		res            = '0;
		res.live       = |ent_mask;
		res.key_hit    = (ent_key == req_key);
		res.goal_hit   = (ent_goal == req_goal);
		res.bit_set    = |(ent_mask & slot_bit);
		res.left_empty = ~|mask_clr;
		res.broken     = (ent_count >= ent_goal);
		res.reached    = (count_next >= ent_goal);
	end

endmodule

FILE: rtl/kbt_ctrl.sv
module kbt_ctrl #(
	parameter int unsigned NUM_BARRIERS = 16,
	parameter int unsigned NUM_PROCS    = 64,
	localparam int unsigned IW = (NUM_BARRIERS > 1) ? $clog2(NUM_BARRIERS) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  kbt_pkg::mode_t                  in_mode,
	input  logic [kbt_pkg::KeyWidth-1:0]    in_key,
	input  logic [kbt_pkg::GoalWidth-1:0]   in_goal,
	input  logic [kbt_pkg::IndexWidth-1:0]  in_index,
	input  logic [kbt_pkg::SlotWidth-1:0]   in_slot,
	input  logic [kbt_pkg::KeyWidth-1:0]    ent_key,
	input  logic [kbt_pkg::GoalWidth-1:0]   ent_goal,
	input  logic [kbt_pkg::GoalWidth-1:0]   ent_count,
	input  logic [NUM_PROCS-1:0]            ent_mask,
	output logic [IW-1:0]                   rd_idx,
	output kbt_pkg::store_wr_t              wr,
	output logic [kbt_pkg::KeyWidth-1:0]    wr_key,
	output logic [kbt_pkg::GoalWidth-1:0]   wr_goal,
	output logic [kbt_pkg::GoalWidth-1:0]   wr_count,
	output logic [NUM_PROCS-1:0]            wr_mask,
	output logic                            done,
	input  logic                            take,
	output kbt_pkg::result_t                result
);

	typedef enum logic [2:0] {
		IDLE,
		SCAN,
		PLACE,
		CLEAN,
		SINGLE,
		FINISH
	} state_t;

	localparam logic [IW-1:0] LastIdx = IW'(NUM_BARRIERS - 1);

	state_t                          state_q;
	kbt_pkg::mode_t                  mode_q;
	logic [kbt_pkg::KeyWidth-1:0]    key_q;
	logic [kbt_pkg::GoalWidth-1:0]   goal_q;
	logic [IW-1:0]                   index_q;
	logic [kbt_pkg::SlotWidth-1:0]   slot_q;
	logic [IW-1:0]                   scan_q;
	logic                            hit_q;
	logic [IW-1:0]                   hit_idx_q;
	logic                            free_q;
	logic [IW-1:0]                   free_idx_q;
	kbt_pkg::result_t                res_q;

	kbt_pkg::unit_res_t              ures;
	logic [NUM_PROCS-1:0]            mask_set;
	logic [NUM_PROCS-1:0]            mask_clr;
	logic [kbt_pkg::GoalWidth-1:0]   count_next;
	logic                            slot_bad;
	logic                            index_bad;
	kbt_pkg::result_t                accept_res;

	kbt_unit #(
		.NUM_PROCS (NUM_PROCS)
	) u_unit (
		.req_key    (key_q),
		.req_goal   (goal_q),
		.req_slot   (slot_q),
		.ent_key    (ent_key),
		.ent_goal   (ent_goal),
		.ent_count  (ent_count),
		.ent_mask   (ent_mask),
		.res        (ures),
		.mask_set   (mask_set),
		.mask_clr   (mask_clr),
		.count_next (count_next)
	);

	assign slot_bad  = ({1'b0, in_slot} >= (kbt_pkg::SlotWidth + 1)'(NUM_PROCS));
	assign index_bad = (in_index >= kbt_pkg::IndexWidth'(NUM_BARRIERS));
	assign in_ready  = (state_q == IDLE);
	assign done      = (state_q == FINISH);
	assign result    = res_q;

	// Starting result of a request: a failed range check is its final answer.
	always_comb begin
		accept_res = '0;
		if ((in_mode == kbt_pkg::MODE_JOIN || in_mode == kbt_pkg::MODE_CLEANUP)
				? slot_bad : index_bad) begin
			accept_res.status = kbt_pkg::ST_RANGE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			mode_q     <= kbt_pkg::MODE_JOIN;
			key_q      <= '0;
			goal_q     <= '0;
			index_q    <= '0;
			slot_q     <= '0;
			scan_q     <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			res_q      <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						mode_q  <= in_mode;
						key_q   <= in_key;
						goal_q  <= in_goal;
						index_q <= in_index[IW-1:0];
						slot_q  <= in_slot;
						scan_q  <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						res_q   <= accept_res;
						unique case (in_mode)
							kbt_pkg::MODE_JOIN, kbt_pkg::MODE_CLEANUP: begin
								if (slot_bad) begin
									state_q <= FINISH;
								end else begin
									state_q <= (in_mode == kbt_pkg::MODE_JOIN) ? SCAN : CLEAN;
								end
							end
							kbt_pkg::MODE_WAIT, kbt_pkg::MODE_DESTROY: begin
								if (index_bad) begin
									state_q <= FINISH;
								end else begin
									state_q <= SINGLE;
								end
							end
						endcase
					end
				end
				SCAN: begin
					// First live entry with the key wins; the lowest free
					// entry is kept in case there is none.
					if (ures.live && ures.key_hit && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= scan_q;
					end
					if (!ures.live && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= scan_q;
					end
					if (scan_q == LastIdx) begin
						state_q <= PLACE;
					end else begin
						scan_q <= scan_q + IW'(1);
					end
				end
				PLACE: begin
					if (hit_q) begin
						res_q.barrier_id <= kbt_pkg::IdWidth'(hit_idx_q);
						if (!ures.goal_hit) begin
							res_q.status <= kbt_pkg::ST_MISMATCH;
						end
					end else if (free_q) begin
						res_q.barrier_id <= kbt_pkg::IdWidth'(free_idx_q);
					end else begin
						res_q.status <= kbt_pkg::ST_FULL;
					end
					state_q <= FINISH;
				end
				CLEAN: begin
					if (ures.bit_set && ures.left_empty) begin
						res_q.released_mask[scan_q] <= 1'b1;
					end
					if (scan_q == LastIdx) begin
						state_q <= FINISH;
					end else begin
						scan_q <= scan_q + IW'(1);
					end
				end
				SINGLE: begin
					if (!ures.live) begin
						res_q.status <= kbt_pkg::ST_NOT_LIVE;
					end else if (mode_q == kbt_pkg::MODE_WAIT) begin
						if (ures.broken) begin
							res_q.status <= kbt_pkg::ST_BROKEN;
						end else if (ures.reached) begin
							res_q.release_waiters <= 1'b1;
						end else begin
							res_q.caller_blocks <= 1'b1;
						end
					end else begin
						res_q.release_waiters <= 1'b1;
					end
					state_q <= FINISH;
				end
				FINISH: begin
					if (take) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	always_comb begin
		unique case (state_q)
			PLACE:   rd_idx = hit_q ? hit_idx_q : free_idx_q;
			SINGLE:  rd_idx = index_q;
			default: rd_idx = scan_q;
		endcase
	end

	always_comb begin
		wr       = '0;
		wr_key   = key_q;
		wr_goal  = goal_q;
		wr_count = count_next;
		wr_mask  = mask_set;
		unique case (state_q)
			PLACE: begin
				if (hit_q) begin
					wr.mask_we = 1'b1;
				end else if (free_q) begin
					// A free entry has an empty mask, so the set mask is the
					// caller's bit alone.
					wr.mask_we = 1'b1;
					wr.meta_we = 1'b1;
					wr_count   = '0;
				end
			end
			CLEAN: begin
				wr.mask_we = ures.bit_set;
				wr_mask    = mask_clr;
			end
			SINGLE: begin
				if (ures.live) begin
					if (mode_q == kbt_pkg::MODE_WAIT) begin
						wr.count_we = !ures.broken;
						wr_count    = ures.reached ? '0 : count_next;
					end else begin
						wr.mask_we = 1'b1;
						wr_mask    = '0;
					end
				end
			end
			default: begin
				wr = '0;
			end
		endcase
	end

endmodule

FILE: rtl/keyed_barrier_table.sv
// A join scans every entry through the single compare unit (SCAN), then updates or
// allocates one (PLACE); cleanup scans every entry (CLEAN); wait and destroy touch
// one entry (SINGLE); an out of range request goes straight to FINISH. No new
// request is taken until the result has been handed to the output register.
// Reset (arst_n, asynchronous, active low) frees every entry at once and idles the
// sequencer; keys, goals and counts are not cleared and are rewritten on allocation.
module keyed_barrier_table #(
	parameter int unsigned NUM_BARRIERS = 16,
	parameter int unsigned NUM_PROCS    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// key[31:0], goal[38:32], barrier_index[46:39], proc_slot[52:47], zero pad[55:53]
	input  logic [55:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0], barrier_id[6:3], caller_blocks[7], release_waiters[8],
	// released_mask[24:9], zero pad[31:25]
	output logic [31:0] m_tdata
);

	localparam int unsigned IW = (NUM_BARRIERS > 1) ? $clog2(NUM_BARRIERS) : 1;

	// Unpacked input fields.
	logic [kbt_pkg::KeyWidth-1:0]   in_key;
	logic [kbt_pkg::GoalWidth-1:0]  in_goal;
	logic [kbt_pkg::IndexWidth-1:0] in_index;
	logic [kbt_pkg::SlotWidth-1:0]  in_slot;
	kbt_pkg::mode_t                 in_mode;

	// Storage access between the sequencer and the entry table.
	logic [IW-1:0]                  rd_idx;
	kbt_pkg::store_wr_t             wr;
	logic [kbt_pkg::KeyWidth-1:0]   wr_key;
	logic [kbt_pkg::GoalWidth-1:0]  wr_goal;
	logic [kbt_pkg::GoalWidth-1:0]  wr_count;
	logic [NUM_PROCS-1:0]           wr_mask;
	logic [kbt_pkg::KeyWidth-1:0]   ent_key;
	logic [kbt_pkg::GoalWidth-1:0]  ent_goal;
	logic [kbt_pkg::GoalWidth-1:0]  ent_count;
	logic [NUM_PROCS-1:0]           ent_mask;

	// Result handoff into the output register.
	logic                           done;
	logic                           take;
	logic                           out_free;
	kbt_pkg::result_t               result;
	kbt_pkg::result_t               out_q;
	logic                           out_valid_q;

	assign in_key   = s_tdata[31:0];
	assign in_goal  = s_tdata[38:32];
	assign in_index = s_tdata[46:39];
	assign in_slot  = s_tdata[52:47];
	assign in_mode  = kbt_pkg::mode_t'(s_tuser);

	kbt_store #(
		.NUM_BARRIERS (NUM_BARRIERS),
		.NUM_PROCS    (NUM_PROCS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_idx    (rd_idx),
		.wr        (wr),
		.wr_key    (wr_key),
		.wr_goal   (wr_goal),
		.wr_count  (wr_count),
		.wr_mask   (wr_mask),
		.ent_key   (ent_key),
		.ent_goal  (ent_goal),
		.ent_count (ent_count),
		.ent_mask  (ent_mask)
	);

	kbt_ctrl #(
		.NUM_BARRIERS (NUM_BARRIERS),
		.NUM_PROCS    (NUM_PROCS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (in_mode),
		.in_key    (in_key),
		.in_goal   (in_goal),
		.in_index  (in_index),
		.in_slot   (in_slot),
		.ent_key   (ent_key),
		.ent_goal  (ent_goal),
		.ent_count (ent_count),
		.ent_mask  (ent_mask),
		.rd_idx    (rd_idx),
		.wr        (wr),
		.wr_key    (wr_key),
		.wr_goal   (wr_goal),
		.wr_count  (wr_count),
		.wr_mask   (wr_mask),
		.done      (done),
		.take      (take),
		.result    (result)
	);

	// The output register frees the sequencer as soon as a result is handed
	// over, so a new request can be taken while the previous result still
	// waits for its transfer.
	assign out_free = !out_valid_q || m_tready;
	assign take     = done && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_q.released_mask, out_q.release_waiters,
		out_q.caller_blocks, out_q.barrier_id, out_q.status};

	// A request transfer always starts a multi-cycle operation.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("sequencer ready again right after a request transfer");

	// A finished result held back by a full output register must not change.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !out_free) |=> (done && $stable(result)))
		else $error("pending result changed while waiting for the output register");

	// Errors other than a goal mismatch carry no slot, wake-up or released entries.
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status != kbt_pkg::ST_OK
			&& out_q.status != kbt_pkg::ST_MISMATCH)
		|-> (out_q.barrier_id == '0 && !out_q.caller_blocks
			&& !out_q.release_waiters && out_q.released_mask == '0))
		else $error("error result carries side information");

endmodule

FILE: test/barrier_table_checker.sv
module barrier_table_checker
	import kbt_pkg::*;
#(
	parameter int unsigned NUM_BARRIERS = 16,
	parameter int unsigned NUM_PROCS    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	output int          fails,
	output int          outstanding
);

	// Shadow copy of the barrier table.
	logic [KeyWidth-1:0]  held_key   [NUM_BARRIERS];
	logic [GoalWidth-1:0] held_goal  [NUM_BARRIERS];
	logic [GoalWidth-1:0] held_count [NUM_BARRIERS];
	logic [63:0]          users      [NUM_BARRIERS];

	result_t owed_results[$];
	result_t want;
	int      result_no;

	task automatic report(input string field, input logic [31:0] expected,
			input logic [31:0] got);
		$display("mismatch in %s of result %0d: expected %0h, got %0h",
			field, result_no, expected, got);
		fails++;
	endtask

	// Applies one call to the shadow table and returns the answer the block owes.
	function automatic result_t resolve_barrier_call(input mode_t mode,
			input logic [KeyWidth-1:0] key, input logic [GoalWidth-1:0] goal,
			input logic [IndexWidth-1:0] index, input logic [SlotWidth-1:0] slot);
		result_t res;
		int      hit;
		logic [FreedWidth-1:0] freed;
		res = '0;
		res.status = ST_OK;
		hit = -1;
		freed = '0;
		case (mode)
			MODE_JOIN: begin
				if (slot >= NUM_PROCS) begin
					res.status = ST_RANGE;
				end else begin
					for (int i = 0; i < NUM_BARRIERS; i++)
						if (hit < 0 && users[i] != '0 && held_key[i] == key)
							hit = i;
					if (hit >= 0) begin
						if (held_goal[hit] != goal)
							res.status = ST_MISMATCH;
					end else begin
						for (int i = 0; i < NUM_BARRIERS; i++)
							if (hit < 0 && users[i] == '0)
								hit = i;
						if (hit >= 0) begin
							held_key[hit]   = key;
							held_goal[hit]  = goal;
							held_count[hit] = '0;
						end else begin
							res.status = ST_FULL;
						end
					end
					if (hit >= 0) begin
						users[hit][slot] = 1'b1;
						res.barrier_id = 4'(hit);
					end
				end
			end
			MODE_WAIT: begin
				if (index >= NUM_BARRIERS) begin
					res.status = ST_RANGE;
				end else if (users[index] == '0) begin
					res.status = ST_NOT_LIVE;
				end else if (held_count[index] >= held_goal[index]) begin
					res.status = ST_BROKEN;
				end else begin
					held_count[index] = held_count[index] + 1'b1;
					if (held_count[index] < held_goal[index]) begin
						res.caller_blocks = 1'b1;
					end else begin
						held_count[index] = '0;
						res.release_waiters = 1'b1;
					end
				end
			end
			MODE_DESTROY: begin
				if (index >= NUM_BARRIERS) begin
					res.status = ST_RANGE;
				end else if (users[index] == '0) begin
					res.status = ST_NOT_LIVE;
				end else begin
					users[index] = '0;
					res.release_waiters = 1'b1;
				end
			end
			default: begin
				if (slot >= NUM_PROCS) begin
					res.status = ST_RANGE;
				end else begin
					for (int i = 0; i < NUM_BARRIERS; i++) begin
						if (users[i][slot]) begin
							users[i][slot] = 1'b0;
							if (users[i] == '0)
								freed[i] = 1'b1;
						end
					end
					res.released_mask = freed;
				end
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BARRIERS; i++)
				users[i] = '0;
			owed_results.delete();
			outstanding = 0;
			result_no = 0;
			fails = 0;
		end else begin
			// A result always trails its request, so the output side is settled
			// before this edge's request is predicted.
			if (m_tvalid && m_tready) begin
				if (owed_results.size() == 0) begin
					report("unrequested result", '0, m_tdata);
				end else begin
					want = owed_results.pop_front();
					if (m_tdata[2:0] != want.status)
						report("status", 32'(want.status), 32'(m_tdata[2:0]));
					if (m_tdata[6:3] != want.barrier_id)
						report("barrier_id", 32'(want.barrier_id), 32'(m_tdata[6:3]));
					if (m_tdata[7] != want.caller_blocks)
						report("caller_blocks", 32'(want.caller_blocks), 32'(m_tdata[7]));
					if (m_tdata[8] != want.release_waiters)
						report("release_waiters", 32'(want.release_waiters),
							32'(m_tdata[8]));
					if (m_tdata[24:9] != want.released_mask)
						report("released_mask", 32'(want.released_mask),
							32'(m_tdata[24:9]));
					if (m_tdata[31:25] != '0)
						report("padding", '0, 32'(m_tdata[31:25]));
				end
				result_no++;
			end
			if (s_tvalid && s_tready) begin
				owed_results.push_back(resolve_barrier_call(mode_t'(s_tuser),
					s_tdata[31:0], s_tdata[38:32], s_tdata[46:39], s_tdata[52:47]));
			end
			outstanding = owed_results.size();
		end
	end

endmodule

FILE: test/tb_keyed_barrier_table.sv
module tb_keyed_barrier_table;
	import kbt_pkg::*;

	localparam int unsigned NumBarriers = 16;
	localparam int unsigned NumProcs    = 64;

	// The slowest legal run is about 1700 transfers plus random stalls on both
	// sides; the limit leaves ample margin.
	localparam int CycleLimit = 400000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// key[31:0], goal[38:32], barrier_index[46:39], proc_slot[52:47], zero pad[55:53]
	logic [55:0] s_tdata;
	// mode[1:0]
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// status[2:0], barrier_id[6:3], caller_blocks[7], release_waiters[8],
	// released_mask[24:9], zero pad[31:25]
	logic [31:0] m_tdata;

	int fails;
	int outstanding;
	int cycles = 0;

	// While set, neither the request side nor the result side inserts idle cycles.
	bit steady;

	// Keys that the random part reuses so that joins find live barriers again.
	logic [31:0] key_pool [8];

	keyed_barrier_table #(
		.NUM_BARRIERS(NumBarriers),
		.NUM_PROCS   (NumProcs)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	barrier_table_checker #(
		.NUM_BARRIERS(NumBarriers),
		.NUM_PROCS   (NumProcs)
	) table_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fails      (fails),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The result side stalls with a chance of about 27 in a hundred, except in the steady stretch.
	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 27);
	end

	// Watchdog: a hung handshake or a lost result ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// Presents one call at a falling edge, after an optional random idle gap, and
	// holds it until the block takes the transfer. A call that follows at once
	// keeps tvalid high, so tvalid never drops and rises within one time step.
	task automatic send(input mode_t mode, input logic [31:0] key,
			input logic [6:0] goal, input logic [7:0] index, input logic [5:0] slot);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 27) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {3'b000, slot, index, goal, key};
		do @(posedge clk); while (!s_tready);
	endtask

	initial begin
		int          kp;
		int          pick;
		logic [31:0] key;
		logic [6:0]  goal;
		logic [7:0]  index;
		logic [5:0]  slot;
		mode_t       mode;

		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = MODE_JOIN;
		steady   = 1'b0;
		arst_n   = 1'b0;
		for (int i = 0; i < 8; i++)
			key_pool[i] = $urandom;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. Out of range indexes and a cleanup on an empty table.
		send(MODE_WAIT, 32'h0, 7'd0, 8'd16, 6'd0);
		send(MODE_DESTROY, 32'h0, 7'd0, 8'd255, 6'd0);
		send(MODE_CLEANUP, 32'h0, 7'd0, 8'd0, 6'd7);

		// Fill every entry: the key extremes, a goal of zero and the largest goal.
		for (int i = 0; i < NumBarriers; i++) begin
			case (i)
				0:       send(MODE_JOIN, 32'h8000_0000, 7'd2, 8'd0, 6'd0);
				1:       send(MODE_JOIN, 32'h7FFF_FFFF, 7'd0, 8'hFF, 6'd63);
				15:      send(MODE_JOIN, 32'(i), 7'd127, 8'd0, 6'(i));
				default: send(MODE_JOIN, 32'(i), 7'(i), 8'd0, 6'(i));
			endcase
		end
		// A new key with no free entry finds the table full.
		send(MODE_JOIN, 32'hFFFF_FFFF, 7'd64, 8'd0, 6'd31);
		// Joining an existing key with another goal is a goal mismatch.
		send(MODE_JOIN, 32'h8000_0000, 7'd5, 8'd0, 6'd9);
		// The first arrival blocks; the second reaches the goal and releases.
		send(MODE_WAIT, 32'h0, 7'd0, 8'd0, 6'd0);
		send(MODE_WAIT, 32'h0, 7'd0, 8'd0, 6'd0);
		// A goal of zero is already reached, so the barrier is broken.
		send(MODE_WAIT, 32'h0, 7'd0, 8'd1, 6'd0);
		send(MODE_DESTROY, 32'h0, 7'd0, 8'd1, 6'd0);
		send(MODE_WAIT, 32'h0, 7'd0, 8'd1, 6'd0);
		// Entry 0 keeps a user after the first cleanup and is freed by the second.
		send(MODE_CLEANUP, 32'h0, 7'd0, 8'd0, 6'd0);
		send(MODE_CLEANUP, 32'h0, 7'd0, 8'd0, 6'd9);

		// Random part. A small pool of keys, goals tied to the key and a handful of
		// process slots make joins meet, waits count up to release and cleanups free
		// entries; rare full-range values supply mismatches, range errors and noise.
		for (int n = 0; n < 1650; n++) begin
			steady = (n >= 700 && n < 1000);
			kp    = $urandom_range(7);
			key   = ($urandom_range(19) == 0) ? $urandom : key_pool[kp];
			goal  = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'(kp % 4 + 1);
			index = ($urandom_range(11) == 0) ? 8'($urandom_range(255))
				: 8'($urandom_range(NumBarriers - 1));
			slot  = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(7));
			pick  = $urandom_range(99);
			if (pick < 35)
				mode = MODE_JOIN;
			else if (pick < 75)
				mode = MODE_WAIT;
			else if (pick < 83)
				mode = MODE_DESTROY;
			else
				mode = MODE_CLEANUP;
			send(mode, key, goal, index, slot);
		end
		steady = 1'b0;

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		// Let a stray late result show up before the verdict.
		repeat (NumBarriers + 4) @(negedge clk);
		if (fails == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
